[rtl/tgsr_pkg.sv]
// shared types and constants for the tile id to source rectangle lookup
// no dependencies; every other file refers to it by scoped names
package tgsr_pkg;

	localparam int NUM_TILESETS = 8;
	localparam int IDX_W = (NUM_TILESETS > 1) ? $clog2(NUM_TILESETS) : 1;
	localparam int CNT_W = $clog2(NUM_TILESETS + 1);
	localparam logic [CNT_W-1:0] NUM_CNT = CNT_W'(NUM_TILESETS);

	// offset is below tile_count, so 16 bits cover dividend and quotient
	localparam int DIV_W = 16;
	localparam int COLS_W = 12;
	localparam int SIZE_W = 10;
	localparam int PROD_W = DIV_W + SIZE_W;
	localparam int STEP_W = $clog2(DIV_W);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_W - 1);

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_RESOLVE = 1'b1;

	typedef struct packed {
		logic        kind;
		logic [2:0]  entry_index;
		logic [28:0] start_id;
		logic [15:0] tile_count;
		logic [11:0] columns;
		logic [9:0]  tile_width;
		logic [9:0]  tile_height;
		logic [28:0] lookup_id;
	} in_word_t;

	typedef struct packed {
		logic        found;
		logic [2:0]  tileset_index;
		logic [21:0] src_x;
		logic [25:0] src_y;
		logic [9:0]  src_width;
		logic [9:0]  src_height;
	} out_word_t;

	typedef struct packed {
		logic [28:0] start_id;
		logic [15:0] tile_count;
		logic [11:0] columns;
		logic [9:0]  tile_width;
		logic [9:0]  tile_height;
	} entry_t;

	typedef struct packed {
		logic       we;
		logic [2:0] index;
		entry_t     entry;
	} tbl_write_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_DIV,
		ST_MUL,
		ST_HOLD
	} state_t;

endpackage

[rtl/tile_gid_source_rect_top.sv]
// top level of the tile id to source rectangle lookup: sequencer, config, output word
// depends on tgsr_pkg, tgsr_table, tgsr_div and tgsr_mul
//
// One input word at a time. A load word writes one tileset entry and returns an all-zero
// result word by way of the hold state. A resolve word scans the table one entry per
// cycle from entry zero (up to tilesets_in_use entries, capped at the table size), then
// runs the serial divider for column and row, then the two serial multipliers for the
// pixel position; a hit in a tileset with zero columns or a miss skips the divide and
// multiply. The block takes a new word as soon as the previous one has moved into the
// output register, even while that result is still stalled. The config register is
// written through cfg_valid/cfg_ready and must only change while the block is idle.
module tile_gid_source_rect_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  tgsr_pkg::in_word_t   in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output tgsr_pkg::out_word_t  out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [3:0]           cfg_data
);

	tgsr_pkg::state_t state_q;
	tgsr_pkg::state_t state_d;

	// config and search bookkeeping
	logic [3:0]                   in_use_q;
	logic [tgsr_pkg::CNT_W-1:0]   limit;
	logic [31:0]                  in_use_ext;
	logic [tgsr_pkg::CNT_W-1:0]   idx_q;
	logic [28:0]                  gid_q;

	// result staging and output register
	tgsr_pkg::out_word_t          res_q;
	tgsr_pkg::out_word_t          out_q;
	logic                         out_valid_q;

	// table port
	tgsr_pkg::tbl_write_t         tbl_wr;
	tgsr_pkg::entry_t             rd_entry;
	logic                         hit;
	logic [tgsr_pkg::DIV_W-1:0]   offset;

	// serial units
	tgsr_pkg::unit_status_t       div_st;
	tgsr_pkg::unit_status_t       mx_st;
	tgsr_pkg::unit_status_t       my_st;
	logic [tgsr_pkg::DIV_W-1:0]   quotient;
	logic [tgsr_pkg::COLS_W-1:0]  remainder;
	logic [tgsr_pkg::PROD_W-1:0]  prod_x;
	logic [tgsr_pkg::PROD_W-1:0]  prod_y;
	logic [tgsr_pkg::SIZE_W-1:0]  width_q;
	logic [tgsr_pkg::SIZE_W-1:0]  height_q;

	// control strobes
	logic accept;
	logic at_end;
	logic div_start;
	logic mul_start;
	logic out_load;

	// search limit is the register clamped to the table size
	assign in_use_ext = 32'(in_use_q);
	assign limit = (in_use_ext > tgsr_pkg::NUM_TILESETS) ? tgsr_pkg::NUM_CNT
		: in_use_ext[tgsr_pkg::CNT_W-1:0];
	assign at_end = (idx_q == limit);

	// config register, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			in_use_q <= cfg_data;
		end
	end

	// table write straight from the accepted load word
	always_comb begin
		tbl_wr.we = accept && (in_data.kind == tgsr_pkg::KIND_LOAD);
		tbl_wr.index = in_data.entry_index;
		tbl_wr.entry.start_id = in_data.start_id;
		tbl_wr.entry.tile_count = in_data.tile_count;
		tbl_wr.entry.columns = in_data.columns;
		tbl_wr.entry.tile_width = in_data.tile_width;
		tbl_wr.entry.tile_height = in_data.tile_height;
	end

	tgsr_table u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (tbl_wr),
		.rd_index (idx_q[tgsr_pkg::IDX_W-1:0]),
		.gid      (gid_q),
		.rd_entry (rd_entry),
		.hit      (hit),
		.offset   (offset)
	);

	// offset -> row (quotient) and column (remainder)
	tgsr_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (offset),
		.divisor   (rd_entry.columns),
		.status    (div_st),
		.quotient  (quotient),
		.remainder (remainder)
	);

	tgsr_mul u_mul_x (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       ({{(tgsr_pkg::DIV_W - tgsr_pkg::COLS_W){1'b0}}, remainder}),
		.b       (width_q),
		.status  (mx_st),
		.product (prod_x)
	);

	tgsr_mul u_mul_y (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       (quotient),
		.b       (height_q),
		.status  (my_st),
		.product (prod_y)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tgsr_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = (in_data.kind == tgsr_pkg::KIND_LOAD) ? tgsr_pkg::ST_HOLD
						: tgsr_pkg::ST_SEARCH;
				end
			end
			tgsr_pkg::ST_SEARCH: begin
				if (at_end) begin
					state_d = tgsr_pkg::ST_HOLD;
				end else if (hit) begin
					state_d = (rd_entry.columns == '0) ? tgsr_pkg::ST_HOLD
						: tgsr_pkg::ST_DIV;
				end
			end
			tgsr_pkg::ST_DIV: begin
				if (div_st.done) begin
					state_d = tgsr_pkg::ST_MUL;
				end
			end
			tgsr_pkg::ST_MUL: begin
				if (mx_st.done) begin
					state_d = tgsr_pkg::ST_HOLD;
				end
			end
			tgsr_pkg::ST_HOLD: begin
				if (out_load) begin
					state_d = tgsr_pkg::ST_IDLE;
				end
			end
			default: state_d = tgsr_pkg::ST_IDLE;
		endcase
	end

	// strobes
	always_comb begin
		in_stall = (state_q != tgsr_pkg::ST_IDLE);
		accept = in_valid && (state_q == tgsr_pkg::ST_IDLE);
		div_start = (state_q == tgsr_pkg::ST_SEARCH) && !at_end && hit
			&& (rd_entry.columns != '0);
		mul_start = (state_q == tgsr_pkg::ST_DIV) && div_st.done;
		out_load = (state_q == tgsr_pkg::ST_HOLD) && (!out_valid_q || !out_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tgsr_pkg::ST_IDLE;
			idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				idx_q <= '0;
			end else if ((state_q == tgsr_pkg::ST_SEARCH) && !at_end && !hit) begin
				idx_q <= idx_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload: result word builds up as the item moves along
	always_ff @(posedge clk) begin
		if (accept) begin
			gid_q <= in_data.lookup_id;
			res_q <= '0;
		end else if ((state_q == tgsr_pkg::ST_SEARCH) && !at_end && hit) begin
			res_q.found <= 1'b1;
			res_q.tileset_index <= idx_q[tgsr_pkg::IDX_W-1:0];
			res_q.src_width <= rd_entry.tile_width;
			res_q.src_height <= rd_entry.tile_height;
			width_q <= rd_entry.tile_width;
			height_q <= rd_entry.tile_height;
		end else if ((state_q == tgsr_pkg::ST_MUL) && mx_st.done) begin
			res_q.src_x <= prod_x[21:0];
			res_q.src_y <= prod_y;
		end
		if (out_load) begin
			out_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	// divider only reports while the sequencer waits for it
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_st.done |-> (state_q == tgsr_pkg::ST_DIV))
		else $error("divider finished outside divide phase");

	// both multipliers start together and must finish together
	a_mul_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		(mx_st.done == my_st.done) && (mx_st.busy == my_st.busy))
		else $error("multipliers out of step");

	// a new output word only comes from the hold phase
	a_out_from_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> out_valid && (state_q == tgsr_pkg::ST_IDLE))
		else $error("output load did not return to idle");

	// a miss or load word leaves every field zero
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && !res_q.found) |=> (out_data == '0))
		else $error("non-zero fields on a miss");

endmodule

[rtl/tgsr_table.sv]
// tileset table in flip-flops with one read port and the range compare
// depends on tgsr_pkg
module tgsr_table (
	input  logic                        clk,
	input  logic                        arst_n,
	input  tgsr_pkg::tbl_write_t        wr,
	input  logic [tgsr_pkg::IDX_W-1:0]  rd_index,
	input  logic [28:0]                 gid,
	output tgsr_pkg::entry_t            rd_entry,
	output logic                        hit,
	output logic [tgsr_pkg::DIV_W-1:0]  offset
);

	tgsr_pkg::entry_t entries_q [tgsr_pkg::NUM_TILESETS];

	logic [29:0] diff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int e = 0; e < tgsr_pkg::NUM_TILESETS; e++) begin
				entries_q[e] <= '0;
			end
		end else begin
			// indexes beyond the table are dropped
			for (int e = 0; e < tgsr_pkg::NUM_TILESETS; e++) begin
				if (wr.we && (32'(wr.index) == e)) begin
					entries_q[e] <= wr.entry;
				end
			end
		end
	end

	assign rd_entry = entries_q[rd_index];

	// zero count never matches since offset < 0 is impossible
	assign diff = {1'b0, gid} - {1'b0, rd_entry.start_id};
	assign hit = !diff[29] && (diff[28:0] < {13'd0, rd_entry.tile_count});
	assign offset = diff[tgsr_pkg::DIV_W-1:0];

endmodule

[rtl/tgsr_div.sv]
// radix-2 restoring divider, one quotient bit per cycle
// depends on tgsr_pkg
module tgsr_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [tgsr_pkg::DIV_W-1:0]   dividend,
	input  logic [tgsr_pkg::COLS_W-1:0]  divisor,
	output tgsr_pkg::unit_status_t       status,
	output logic [tgsr_pkg::DIV_W-1:0]   quotient,
	output logic [tgsr_pkg::COLS_W-1:0]  remainder
);

	logic                         busy_q;
	logic                         done_q;
	logic [tgsr_pkg::STEP_W-1:0]  cnt_q;
	logic [tgsr_pkg::DIV_W-1:0]   quo_q;
	logic [tgsr_pkg::COLS_W-1:0]  rem_q;
	logic [tgsr_pkg::COLS_W-1:0]  dsr_q;

	logic [tgsr_pkg::COLS_W:0] rem_sh;
	logic [tgsr_pkg::COLS_W:0] trial;

	assign rem_sh = {rem_q, quo_q[tgsr_pkg::DIV_W-1]};
	assign trial = rem_sh - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == tgsr_pkg::LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			if (!trial[tgsr_pkg::COLS_W]) begin
				rem_q <= trial[tgsr_pkg::COLS_W-1:0];
				quo_q <= {quo_q[tgsr_pkg::DIV_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[tgsr_pkg::COLS_W-1:0];
				quo_q <= {quo_q[tgsr_pkg::DIV_W-2:0], 1'b0};
			end
		end
	end

	assign status = '{busy: busy_q, done: done_q};
	assign quotient = quo_q;
	assign remainder = rem_q;

endmodule

[rtl/tgsr_mul.sv]
// bit-serial shift-and-add multiplier, one multiplier bit per cycle
// depends on tgsr_pkg
module tgsr_mul (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [tgsr_pkg::DIV_W-1:0]   a,
	input  logic [tgsr_pkg::SIZE_W-1:0]  b,
	output tgsr_pkg::unit_status_t       status,
	output logic [tgsr_pkg::PROD_W-1:0]  product
);

	logic                         busy_q;
	logic                         done_q;
	logic [tgsr_pkg::STEP_W-1:0]  cnt_q;
	logic [tgsr_pkg::DIV_W-1:0]   a_q;
	logic [tgsr_pkg::PROD_W-1:0]  b_q;
	logic [tgsr_pkg::PROD_W-1:0]  acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == tgsr_pkg::LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= {{tgsr_pkg::DIV_W{1'b0}}, b};
			acc_q <= '0;
		end else if (busy_q) begin
			a_q <= {1'b0, a_q[tgsr_pkg::DIV_W-1:1]};
			b_q <= {b_q[tgsr_pkg::PROD_W-2:0], 1'b0};
			if (a_q[0]) begin
				acc_q <= acc_q + b_q;
			end
		end
	end

	assign status = '{busy: busy_q, done: done_q};
	assign product = acc_q;

endmodule
